// File: design/gcl_pkg.sv
// shared types and constants for the gcd / lcm unit
`default_nettype none

package gcl_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FIELD_WIDTH    = 32;

   typedef enum logic {
      OP_GCD = 1'b0,
      OP_LCM = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_MUL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic gcd_step;
      logic gcd_fin;
      logic div_step;
      logic mul_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic lcm_path;
   } status_type;

endpackage

`default_nettype wire

// File: design/gcl_if.sv
// request and response channel interfaces
`default_nettype none

interface gcl_req_if
   import gcl_pkg::*;
();
   logic                   valid;
   logic                   ready;
   op_type                 op;
   logic [FIELD_WIDTH-1:0] operand_a;
   logic [FIELD_WIDTH-1:0] operand_b;

   modport source (output valid, output op, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input op, input operand_a, input operand_b,
                   output ready);
endinterface

interface gcl_rsp_if
   import gcl_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] result;
   logic                   overflow;

   modport source (output valid, output result, output overflow, input ready);
   modport sink   (input valid, input result, input overflow, output ready);
endinterface

`default_nettype wire

// File: design/gcl_ctrl.sv
// controller state machine: sequences gcd, divide, multiply and result hand-off
`default_nettype none

module gcl_ctrl
   import gcl_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             cnt_last;
   logic             out_free;

   assign cnt_last  = (cnt_ff == CNT_LAST);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_GCD;
         end
         ST_GCD: begin
            if (status.gcd_done) state_in = status.lcm_path ? ST_DIV : ST_FINISH;
         end
         ST_DIV: begin
            if (cnt_last) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (cnt_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_GCD: begin
            cmd.gcd_step = !status.gcd_done;
            cmd.gcd_fin  = status.gcd_done;
         end
         ST_DIV:    cmd.div_step = 1'b1;
         ST_MUL:    cmd.mul_step = 1'b1;
         ST_FINISH: cmd.out_load = out_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      if ((state_ff == ST_DIV || state_ff == ST_MUL) && !cnt_last) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = '0;
      end
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: design/gcl_dpath.sv
// datapath: binary gcd, shift-subtract divide, shift-add multiply, result register
`default_nettype none

module gcl_dpath
   import gcl_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire cmd_type                cmd,
   output      status_type             status,
   input  wire op_type                 op,
   input  wire logic [FIELD_WIDTH-1:0] operand_a,
   input  wire logic [FIELD_WIDTH-1:0] operand_b,
   output      logic [FIELD_WIDTH-1:0] result,
   output      logic                   overflow
);

   localparam int W    = DATA_WIDTH;
   localparam int KW   = $clog2(DATA_WIDTH);
   localparam int EW   = (DATA_WIDTH > FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH;

   op_type          op_ff;
   logic [W-1:0]    a_ff, b_ff;
   logic [W-1:0]    x_ff, y_ff, x_in, y_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [W-1:0]    g_ff;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W-1:0]    hi_ff, hi_in;
   logic [FIELD_WIDTH-1:0] result_ff;
   logic            overflow_ff;

   logic [EW-1:0]   a_ext, b_ext, r_ext;
   logic [W-1:0]    a_new, b_new;
   logic [W:0]      rem_sh, rem_diff, msum;
   logic            rem_ge;
   logic [W-1:0]    res_w;
   logic            ovf_w;
   logic            a_zero, b_zero;

   assign a_ext = EW'(operand_a);
   assign b_ext = EW'(operand_b);
   assign a_new = a_ext[W-1:0];
   assign b_new = b_ext[W-1:0];

   assign a_zero = (a_ff == '0);
   assign b_zero = (b_ff == '0);
   assign status.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign status.lcm_path = (op_ff == OP_LCM) && !a_zero && !b_zero;

   // one binary gcd step
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      k_in = k_ff;
      priority if (!x_ff[0] && !y_ff[0]) begin
         x_in = x_ff >> 1;
         y_in = y_ff >> 1;
         k_in = k_ff + KW'(1);
      end else if (!x_ff[0]) begin
         x_in = x_ff >> 1;
      end else if (!y_ff[0]) begin
         y_in = y_ff >> 1;
      end else if (x_ff >= y_ff) begin
         x_in = (x_ff - y_ff) >> 1;
      end else begin
         y_in = (y_ff - x_ff) >> 1;
      end
   end

   // restoring divide of a by g, one quotient bit per cycle
   assign rem_sh   = {rem_ff, quo_ff[W-1]};
   assign rem_diff = rem_sh - {1'b0, g_ff};
   assign rem_ge   = (rem_sh >= {1'b0, g_ff});

   // shift-add multiply of quotient by b, one multiplier bit per cycle
   assign msum = {1'b0, hi_ff} + (quo_ff[0] ? {1'b0, b_ff} : '0);

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      hi_in  = hi_ff;
      priority if (cmd.gcd_fin) begin
         rem_in = '0;
         quo_in = a_ff;
         hi_in  = '0;
      end else if (cmd.div_step) begin
         rem_in = rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
         quo_in = {quo_ff[W-2:0], rem_ge};
      end else if (cmd.mul_step) begin
         hi_in  = msum[W:1];
         quo_in = {msum[0], quo_ff[W-1:1]};
      end else begin
         rem_in = rem_ff;
      end
   end

   always_comb begin
      ovf_w = 1'b0;
      priority if (op_ff == OP_GCD) begin
         res_w = g_ff;
      end else if (a_zero || b_zero) begin
         res_w = b_zero ? a_ff : b_ff;
      end else begin
         res_w = quo_ff;
         ovf_w = (hi_ff != '0);
      end
   end

   assign r_ext = EW'(res_w);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op;
         a_ff  <= a_new;
         b_ff  <= b_new;
         x_ff  <= a_new;
         y_ff  <= b_new;
         k_ff  <= '0;
      end else if (cmd.gcd_step) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         k_ff  <= k_in;
      end
      if (cmd.gcd_fin) begin
         g_ff <= (x_ff | y_ff) << k_ff;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      hi_ff  <= hi_in;
      if (cmd.out_load) begin
         result_ff   <= r_ext[FIELD_WIDTH-1:0];
         overflow_ff <= ovf_w;
      end
   end

   assign result   = result_ff;
   assign overflow = overflow_ff;

endmodule

`default_nettype wire

// File: design/gcl_lcm_top_placeholder.sv
// top level of the gcd / lcm unit
`default_nettype none
// gcd_lcm_unit: greatest common divisor or least common multiple of two operands
//
// req_ch carries op and two unsigned operands; one result item per request
// comes back on rsp_ch with the result and an lcm overflow flag.
// an item is taken when req_ch.ready is high, which is only while the unit
// is idle; one item is worked on at a time.
// gcd: binary gcd loop, one step per cycle.
// lcm: gcd loop, then a shift-subtract divide of a by the gcd and a
// shift-add multiply of the quotient by b.
// lcm with a zero operand skips divide and multiply.
// loading the operands and writing the result register are steps of their own.
// the result register parts the two sides: a new item is taken while an
// earlier result still waits; a stalled receiver holds the unit only when a
// second result is ready to be written.
// reset is synchronous and clears the controller and the response valid.
module gcd_lcm_unit
   import gcl_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   gcl_req_if.sink   req_ch,
   gcl_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   gcl_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gcl_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .cmd       (cmd),
      .status    (status),
      .op        (req_ch.op),
      .operand_a (req_ch.operand_a),
      .operand_b (req_ch.operand_b),
      .result    (rsp_ch.result),
      .overflow  (rsp_ch.overflow)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("unit took an item while busy");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(!req_ch.ready))
      else $error("result item raised outside the finish step");

   a_reset_clears_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid set right after reset");

endmodule

`default_nettype wire

// File: bench/tb.sv
// testbench for gcd_lcm_unit: random and corner-case gcd / lcm items checked against a predictor
`timescale 1ns / 1ps

module tb;
   import gcl_pkg::*;

   localparam int N_RANDOM    = 1328;
   localparam int HOLD_CYCLES = 500;
   localparam int IDLE_LIMIT  = 5000;
   localparam int TAIL_CYCLES = 300;

   typedef struct {
      op_type                 op;
      logic [FIELD_WIDTH-1:0] operand_a;
      logic [FIELD_WIDTH-1:0] operand_b;
   } gcl_request_type;

   typedef struct {
      logic [FIELD_WIDTH-1:0] result;
      logic                   overflow;
   } gcl_answer_type;

   logic clock;
   logic reset = 1'b1;

   gcl_req_if req_ch ();
   gcl_rsp_if rsp_ch ();

   gcd_lcm_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gcl_request_type request_fifo[$];
   gcl_answer_type  pending_answers[$];

   int   n_sent      = 0;
   int   n_checked   = 0;
   int   n_errors    = 0;
   int   req_gap     = 0;
   int   rsp_stall   = 0;
   int   hold_left   = 0;
   int   hold_mark   = 400;
   int   holds_done  = 0;
   logic req_accepted = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.op        = OP_GCD;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      rsp_ch.ready     = 1'b0;
   end

   function automatic logic [FIELD_WIDTH-1:0] euclid_gcd(logic [FIELD_WIDTH-1:0] x,
                                                         logic [FIELD_WIDTH-1:0] y);
      logic [FIELD_WIDTH-1:0] t;
      if (x < y) begin
         t = x;
         x = y;
         y = t;
      end
      if (y == 0) return x;
      while (x % y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return y;
   endfunction

   function automatic gcl_answer_type gcd_lcm_of(gcl_request_type req);
      gcl_answer_type             ans;
      logic [FIELD_WIDTH-1:0]     g;
      logic [FIELD_WIDTH-1:0]     q;
      logic [2*FIELD_WIDTH-1:0]   prod;
      ans.result   = '0;
      ans.overflow = 1'b0;
      if (req.op == OP_GCD) begin
         ans.result = euclid_gcd(req.operand_a, req.operand_b);
      end else if (req.operand_a != 0 && req.operand_b != 0) begin
         g    = euclid_gcd(req.operand_a, req.operand_b);
         q    = req.operand_a / g;
         prod = {{FIELD_WIDTH{1'b0}}, q} * {{FIELD_WIDTH{1'b0}}, req.operand_b};
         ans.result   = prod[FIELD_WIDTH-1:0];
         ans.overflow = |prod[2*FIELD_WIDTH-1:FIELD_WIDTH];
      end else if (req.operand_b != 0) begin
         ans.result = req.operand_b;
      end else begin
         ans.result = req.operand_a;
      end
      return ans;
   endfunction

   // mostly short gaps, a few long ones, none at all in quiet phases
   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 98) return $urandom_range(5, 20);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 3);
         1: return 32'h1 << $urandom_range(0, FIELD_WIDTH - 1);
         2: return $urandom_range(1, 65535);
         3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_req(op_type op, logic [FIELD_WIDTH-1:0] a,
                            logic [FIELD_WIDTH-1:0] b);
      gcl_request_type req;
      req.op        = op;
      req.operand_a = a;
      req.operand_b = b;
      request_fifo.push_back(req);
   endtask

   task automatic report_mismatch(string what, logic [FIELD_WIDTH-1:0] got,
                                  logic [FIELD_WIDTH-1:0] want);
      $display("mismatch %s: got %h, want %h at result %0d", what, got, want, n_checked);
      n_errors++;
   endtask

   // driver
   always @(negedge clock) begin
      gcl_request_type req;
      if (!reset) begin
         if (!req_ch.valid || req_accepted) begin
            if (req_gap > 0) begin
               req_ch.valid <= 1'b0;
               req_gap      <= req_gap - 1;
            end else if (request_fifo.size() > 0) begin
               req = request_fifo.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.op        <= req.op;
               req_ch.operand_a <= req.operand_a;
               req_ch.operand_b <= req.operand_b;
               req_gap          <= pick_gap((n_sent / 150) % 3 == 1);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver ready, with long hold-offs to back the unit up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (n_checked >= hold_mark && holds_done < 2) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         holds_done   <= holds_done + 1;
         hold_mark    <= hold_mark + 600;
      end else if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= rsp_stall - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         rsp_stall    <= pick_gap((n_checked / 150) % 3 == 2);
      end
   end

   // monitor
   always @(posedge clock) begin
      gcl_request_type req;
      gcl_answer_type  want;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("unexpected item", rsp_ch.result, '0);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_ch.result !== want.result)
                  report_mismatch("result", rsp_ch.result, want.result);
               if (rsp_ch.overflow !== want.overflow)
                  report_mismatch("overflow", 32'(rsp_ch.overflow), 32'(want.overflow));
            end
            n_checked++;
         end
         if (req_ch.valid && req_ch.ready) begin
            req.op        = req_ch.op;
            req.operand_a = req_ch.operand_a;
            req.operand_b = req_ch.operand_b;
            pending_answers.push_back(gcd_lcm_of(req));
            n_sent++;
         end
      end
   end

   // watchdog
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
         else idle++;
      end
      $display("gcd_lcm_unit regression: fail");
      $finish;
   end

   initial begin
      int                     total;
      int                     n;
      logic [FIELD_WIDTH-1:0] a;
      logic [FIELD_WIDTH-1:0] b;
      logic [FIELD_WIDTH-1:0] g;
      logic [FIELD_WIDTH-1:0] t;
      op_type                 op;

      // zero operands, extremes, worst-case euclid, overflow edges
      queue_req(OP_GCD, 32'd0, 32'd0);
      queue_req(OP_GCD, 32'd37, 32'd0);
      queue_req(OP_GCD, 32'd0, 32'd37);
      queue_req(OP_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(OP_GCD, 32'hFFFF_FFFF, 32'd1);
      queue_req(OP_GCD, 32'd1836311903, 32'd2971215073);
      queue_req(OP_GCD, 32'd4294967291, 32'd4294967279);
      queue_req(OP_GCD, 32'd12, 32'd18);
      queue_req(OP_GCD, 32'h8000_0000, 32'hC000_0000);
      queue_req(OP_LCM, 32'd0, 32'd0);
      queue_req(OP_LCM, 32'd0, 32'hFFFF_FFFF);
      queue_req(OP_LCM, 32'hFFFF_FFFF, 32'd0);
      queue_req(OP_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      queue_req(OP_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(OP_LCM, 32'h8000_0000, 32'd2);
      queue_req(OP_LCM, 32'h8000_0000, 32'd3);
      queue_req(OP_LCM, 32'd65536, 32'd65537);
      queue_req(OP_LCM, 32'd4, 32'd6);
      queue_req(OP_LCM, 32'd1, 32'd1);
      queue_req(OP_LCM, 32'd4294967291, 32'd4294967279);
      queue_req(OP_LCM, 32'd1836311903, 32'd2971215073);
      queue_req(OP_LCM, 32'h0000_FFFF, 32'h0001_0001);

      for (int i = 0; i < N_RANDOM; i++) begin
         op = op_type'($urandom_range(0, 1));
         n  = $urandom_range(0, 9);
         if (n < 4) begin
            a = pick_operand();
            b = pick_operand();
         end else if (n < 8) begin
            // shared factor so the gcd is not trivial
            g = $urandom_range(1, 65535);
            a = g * $urandom_range(1, 65535);
            b = g * $urandom_range(1, 65535);
         end else if (n == 8) begin
            a = pick_operand();
            b = ($urandom_range(0, 1) == 1) ? a : a * $urandom_range(1, 7);
         end else begin
            // consecutive fibonacci numbers, longest euclid runs
            a = 32'd1;
            b = 32'd1;
            repeat ($urandom_range(1, 45)) begin
               t = a + b;
               a = b;
               b = t;
            end
         end
         if ($urandom_range(0, 1) == 1) queue_req(op, a, b);
         else queue_req(op, b, a);
      end
      total = request_fifo.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (n_sent == total && pending_answers.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (n_errors == 0 && pending_answers.size() == 0)
         $display("gcd_lcm_unit regression: pass");
      else
         $display("gcd_lcm_unit regression: fail");
      $finish;
   end

endmodule

// File: files.f
design/gcl_pkg.sv
design/gcl_if.sv
design/gcl_ctrl.sv
design/gcl_dpath.sv
design/gcl_lcm_top_placeholder.sv
bench/tb.sv
